/* hdl/mpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_pkg: shared types and constants of the MAC PDU reassembler
// Header type bits, fragment control and status codes, buffer capacity and
// the structs passed between the header decoder and the state tracker.
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int BUFFER_BYTES         = 2048;
  localparam int GENERIC_HEADER_BYTES = 6;

  // Capacity is limited so that a length always fits 12 bits.
  localparam int CAPACITY_INT = (BUFFER_BYTES > 4095) ? 4095 : BUFFER_BYTES;
  localparam logic [11:0] CAPACITY = CAPACITY_INT[11:0];

  // Header type bit positions
  localparam int TY_GRANT_BIT = 0;
  localparam int TY_PACK_BIT  = 1;
  localparam int TY_FRAG_BIT  = 2;
  localparam int TY_EXT_BIT   = 3;
  localparam int TY_ARQ_BIT   = 4;
  localparam int TY_MESH_BIT  = 5;

  // Fragment control codes
  localparam logic [1:0] FC_NONE   = 2'd0;
  localparam logic [1:0] FC_LAST   = 2'd1;
  localparam logic [1:0] FC_FIRST  = 2'd2;
  localparam logic [1:0] FC_MIDDLE = 2'd3;

  // Reassembly status codes
  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_COMPLETE   = 2'd2;
  localparam logic [1:0] ST_EXTERNAL   = 2'd3;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  typedef struct packed {
    logic [3:0] offset;
    logic       frag;
    logic       plain;
  } hdr_info_t;

  typedef struct packed {
    logic [3:0]  payload_offset;
    logic        seq_error;
    logic        partial_dropped;
    logic        overflow;
    logic        malformed;
    logic [1:0]  status;
    logic        packet_ready;
    logic [11:0] packet_length;
  } result_t;

endpackage

/* hdl/mac_pdu_reassembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_pdu_reassembler: receive-side MAC PDU fragment reassembly control
//
// Input channel (in_valid / in_stall) takes one word per PDU header: an
// insert (opcode 0) with type bits, fragment control, sequence and PDU
// length, or a fetch (opcode 1) of a finished packet. Every word gives
// exactly one result word on the output channel (out_valid / out_stall):
// payload offset, error flags, status and packet length.
// A word accepted from the input channel sits in the input register, and its
// result is loaded into the output register when the output is free.
// Throughput is one word per cycle while out_stall is low; the decode and
// state update is one short combinational pass between the two registers,
// and the state registers update as the word moves into the output register.
// While out_stall is high the result is held; the input register then
// fills and in_stall rises, so at most two words are in flight.
// Reset (rst, synchronous) empties both registers and clears the state to
// no data, length zero, last sequence zero.
// ----------------------------------------------------------------------------
module mac_pdu_reassembler
  import mpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [5:0]  type_bits,
  input  logic [1:0]  frag_control,
  input  logic [2:0]  frag_seq,
  input  logic [10:0] pdu_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  payload_offset,
  output logic        seq_error,
  output logic        partial_dropped,
  output logic        overflow,
  output logic        malformed,
  output logic [1:0]  status,
  output logic        packet_ready,
  output logic [11:0] packet_length
);

  logic        s1_valid;
  logic        s1_opcode;
  logic [5:0]  s1_type_bits;
  logic [1:0]  s1_frag_control;
  logic [2:0]  s1_frag_seq;
  logic [10:0] s1_pdu_length;
  logic        out_free;
  logic        advance;
  logic        in_accept;
  hdr_info_t   info;
  result_t     result;
  result_t     out_word;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  mpr_hdr_decode u_decode (
    .type_bits (s1_type_bits),
    .info      (info)
  );

  mpr_reasm_state u_state (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .opcode       (s1_opcode),
    .info         (info),
    .frag_control (s1_frag_control),
    .frag_seq     (s1_frag_seq),
    .pdu_length   (s1_pdu_length),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode       <= opcode;
      s1_type_bits    <= type_bits;
      s1_frag_control <= frag_control;
      s1_frag_seq     <= frag_seq;
      s1_pdu_length   <= pdu_length;
    end
    if (advance) begin
      out_word <= result;
    end
  end

  assign payload_offset  = out_word.payload_offset;
  assign seq_error       = out_word.seq_error;
  assign partial_dropped = out_word.partial_dropped;
  assign overflow        = out_word.overflow;
  assign malformed       = out_word.malformed;
  assign status          = out_word.status;
  assign packet_ready    = out_word.packet_ready;
  assign packet_length   = out_word.packet_length;

endmodule

/* hdl/mpr_hdr_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_hdr_decode: subheader decode
// Works out the payload offset from the header type bits and flags
// fragmented and plain (non-ARQ, non-extended) fragment PDUs.
// ----------------------------------------------------------------------------
module mpr_hdr_decode
  import mpr_pkg::*;
(
  input  logic [5:0] type_bits,
  output hdr_info_t  info
);

  logic       arq_ext;
  logic [3:0] mesh_bytes;
  logic [3:0] grant_bytes;
  logic [3:0] frag_bytes;
  logic [3:0] pack_bytes;

  always_comb begin
    arq_ext     = type_bits[TY_ARQ_BIT] | type_bits[TY_EXT_BIT];
    mesh_bytes  = type_bits[TY_MESH_BIT]  ? 4'd2 : 4'd0;
    grant_bytes = type_bits[TY_GRANT_BIT] ? 4'd2 : 4'd0;
    frag_bytes  = !type_bits[TY_FRAG_BIT] ? 4'd0 : (arq_ext ? 4'd2 : 4'd1);
    pack_bytes  = !type_bits[TY_PACK_BIT] ? 4'd0 : (arq_ext ? 4'd3 : 4'd2);
    info.offset = 4'(GENERIC_HEADER_BYTES) + mesh_bytes + grant_bytes
                  + frag_bytes + pack_bytes;
    info.frag   = type_bits[TY_FRAG_BIT];
    info.plain  = type_bits[TY_FRAG_BIT] & !arq_ext;
  end

endmodule

/* hdl/mpr_reasm_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_reasm_state: reassembly state tracker
// Holds last sequence number, assembled length and status; builds the
// result word of each item and updates the state when the item advances.
// ----------------------------------------------------------------------------
module mpr_reasm_state
  import mpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        opcode,
  input  hdr_info_t   info,
  input  logic [1:0]  frag_control,
  input  logic [2:0]  frag_seq,
  input  logic [10:0] pdu_length,
  output result_t     result
);

  logic [2:0]  last_seq;
  logic [2:0]  last_seq_next;
  logic [11:0] assembled_length;
  logic [11:0] assembled_length_next;
  logic [1:0]  reassembly_status;
  logic [1:0]  reassembly_status_next;

  logic        bad;
  logic [10:0] payload;
  logic        serr;
  logic [1:0]  st_a;
  logic [11:0] len_a;
  logic        pdrop;
  logic        ovf;
  logic        ready;
  logic [12:0] total;
  logic        payload_big;

  always_comb begin
    last_seq_next          = last_seq;
    assembled_length_next  = assembled_length;
    reassembly_status_next = reassembly_status;
    bad         = 1'b0;
    payload     = pdu_length - 11'(info.offset);
    serr        = 1'b0;
    st_a        = reassembly_status;
    len_a       = assembled_length;
    pdrop       = 1'b0;
    ovf         = 1'b0;
    ready       = 1'b0;
    total       = 13'(assembled_length) + 13'(payload);
    payload_big = 12'(payload) > CAPACITY;

    if (opcode == OP_FETCH) begin
      if (reassembly_status == ST_COMPLETE || reassembly_status == ST_EXTERNAL) begin
        ready                  = 1'b1;
        reassembly_status_next = ST_NONE;
        assembled_length_next  = '0;
      end
    end else if (pdu_length < 11'(info.offset)) begin
      bad = 1'b1;
    end else begin
      // Sequence check on plain fragments; a miss drops held data
      if (info.plain) begin
        last_seq_next = frag_seq;
        if (frag_seq != last_seq + 3'd1) begin
          serr  = 1'b1;
          pdrop = (reassembly_status != ST_NONE);
          st_a  = ST_NONE;
          len_a = '0;
        end
      end
      reassembly_status_next = st_a;
      assembled_length_next  = len_a;
      if (!info.frag) begin
        pdrop                  = pdrop | (st_a != ST_NONE);
        reassembly_status_next = ST_EXTERNAL;
        assembled_length_next  = 12'(payload);
      end else if (frag_control == FC_NONE || frag_control == FC_FIRST) begin
        pdrop = pdrop | (st_a != ST_NONE);
        if (payload_big) begin
          ovf                    = 1'b1;
          reassembly_status_next = ST_NONE;
          assembled_length_next  = '0;
        end else begin
          reassembly_status_next = (frag_control == FC_NONE) ? ST_COMPLETE : ST_INCOMPLETE;
          assembled_length_next  = 12'(payload);
        end
      end else if (st_a == ST_INCOMPLETE) begin
        if (total > 13'(CAPACITY)) begin
          ovf                    = 1'b1;
          pdrop                  = 1'b1;
          reassembly_status_next = ST_NONE;
          assembled_length_next  = '0;
        end else begin
          assembled_length_next  = total[11:0];
          reassembly_status_next = (frag_control == FC_LAST) ? ST_COMPLETE : ST_INCOMPLETE;
        end
      end
    end

    result.payload_offset  = (opcode == OP_FETCH) ? 4'd0 : info.offset;
    result.seq_error       = serr;
    result.partial_dropped = pdrop;
    result.overflow        = ovf;
    result.malformed       = bad;
    result.packet_ready    = ready;
    if (opcode == OP_FETCH) begin
      result.status        = reassembly_status;
      result.packet_length = assembled_length;
    end else begin
      result.status        = reassembly_status_next;
      result.packet_length = assembled_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq          <= '0;
      assembled_length  <= '0;
      reassembly_status <= ST_NONE;
    end else if (advance) begin
      last_seq          <= last_seq_next;
      assembled_length  <= assembled_length_next;
      reassembly_status <= reassembly_status_next;
    end
  end

  // No data always means zero length
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    reassembly_status == ST_NONE |-> assembled_length == 12'd0)
    else $error("status none with nonzero length");

  // Fragment buffers never pass the capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    reassembly_status != ST_EXTERNAL |-> assembled_length <= CAPACITY)
    else $error("assembled length past capacity");

  // A handed-out packet leaves the buffer empty
  a_fetch_clears: assert property (@(posedge clk) disable iff (rst)
    advance && result.packet_ready |=> reassembly_status == ST_NONE)
    else $error("fetch did not clear buffer");

  // A malformed PDU touches no state
  a_bad_stable: assert property (@(posedge clk) disable iff (rst)
    advance && result.malformed |=>
      $stable(reassembly_status) && $stable(assembled_length) && $stable(last_seq))
    else $error("malformed item changed state");

  // Overflow always ends with an empty buffer
  a_ovf_empty: assert property (@(posedge clk) disable iff (rst)
    advance && result.overflow |=> reassembly_status == ST_NONE)
    else $error("overflow left data held");

endmodule
